/* rtl/frt_pkg.sv */
// Shared types, constants and helper functions of the fragment reassembly tracker.
// Depends on nothing; every other file refers to it by scoped names.
package frt_pkg;

    // Table geometry.
    localparam int ENTRIES   = 8;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int MAX_FRAGS = 64;
    localparam int MAP_W     = 64;
    localparam int BIT_W     = $clog2(MAP_W);
    localparam int TOT_W     = 7;

    // Result status codes.
    localparam logic [3:0] ST_INVALID   = 4'd0;
    localparam logic [3:0] ST_ZERO      = 4'd1;
    localparam logic [3:0] ST_TOO_MANY  = 4'd2;
    localparam logic [3:0] ST_FULL      = 4'd3;
    localparam logic [3:0] ST_RANGE     = 4'd4;
    localparam logic [3:0] ST_DUP       = 4'd5;
    localparam logic [3:0] ST_STORED    = 4'd6;
    localparam logic [3:0] ST_COMPLETE  = 4'd7;
    localparam logic [3:0] ST_NACK      = 4'd8;
    localparam logic [3:0] ST_NACK_NONE = 4'd9;
    localparam logic [3:0] ST_PURGED    = 4'd10;

    // Request kinds.
    localparam logic [1:0] REQ_FRAG  = 2'd0;
    localparam logic [1:0] REQ_CHECK = 2'd1;
    localparam logic [1:0] REQ_PURGE = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // Frame classes.
    localparam logic [1:0] CLS_AUDIO = 2'd0;
    localparam logic [1:0] CLS_KEY   = 2'd1;
    localparam logic [1:0] CLS_PRED  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NACK_AGE  = 3'd0;
    localparam logic [2:0] CFG_STALE     = 3'd1;
    localparam logic [2:0] CFG_KEY_MASK  = 3'd2;
    localparam logic [2:0] CFG_AUDIO     = 3'd3;

    // One table entry as kept in the entry memory.
    typedef struct packed {
        logic [TOT_W-1:0] total;
        logic [TOT_W-1:0] count;
        logic [7:0]       flags;
        logic [31:0]      pts;
        logic [31:0]      created;
        logic             nacked;
        logic [MAP_W-1:0] rmap;
    } entry_rec_t;

    // One result item.
    typedef struct packed {
        logic [3:0]       status;
        logic [IDX_W-1:0] slot;
        logic [31:0]      fid;
        logic [1:0]       fclass;
        logic [TOT_W-1:0] total;
        logic [31:0]      pts;
        logic [MAP_W-1:0] miss;
        logic [3:0]       purged;
        logic             last;
    } result_t;

    // Commands to the key tag table.
    typedef struct packed {
        logic             set;
        logic [IDX_W-1:0] set_idx;
        logic             clr;
        logic [IDX_W-1:0] clr_idx;
    } tag_cmd_t;

    // Lookup answers from the key tag table.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
    } tag_stat_t;

    // Mask of the lowest n fragment bits.
    function automatic logic [MAP_W-1:0] low_mask(input logic [TOT_W-1:0] n);
        logic [MAP_W-1:0] m;
        if (n >= TOT_W'(MAP_W))
            m = '1;
        else
            m = (MAP_W'(1) << n) - MAP_W'(1);
        return m;
    endfunction

endpackage

/* rtl/frt_entry_ram.sv */
// Entry memory of the tracker: one record per table slot, one write and one read port.
// Depends on frt_pkg for the record type; read data is registered.
module frt_entry_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [frt_pkg::IDX_W-1:0]    waddr,
    input  frt_pkg::entry_rec_t          wdata,
    input  logic [frt_pkg::IDX_W-1:0]    raddr,
    output frt_pkg::entry_rec_t          rdata
);

    frt_pkg::entry_rec_t mem [frt_pkg::ENTRIES];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/frt_tag_match.sv */
// Key tag table of the tracker: valid bits, frame ids and packet types with a parallel match.
// Depends on frt_pkg for the command and status structs.
module frt_tag_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [31:0]                   key_frame,
    input  logic [7:0]                    key_kind,
    input  frt_pkg::tag_cmd_t             cmd,
    input  logic [frt_pkg::IDX_W-1:0]     sel_idx,
    output frt_pkg::tag_stat_t            stat,
    output logic [31:0]                   sel_frame,
    output logic [frt_pkg::ENTRIES-1:0]   valid
);

    logic [frt_pkg::ENTRIES-1:0] valid_reg;
    logic [31:0]                 frame_reg [frt_pkg::ENTRIES];
    logic [7:0]                  kind_reg  [frt_pkg::ENTRIES];

    // Valid bits are control state and clear at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.set)
            begin
                valid_reg[cmd.set_idx] <= 1'b1;
            end
            if (cmd.clr)
            begin
                valid_reg[cmd.clr_idx] <= 1'b0;
            end
        end
    end

    // Key fields are written when an entry is created.
    always_ff @(posedge clk)
    begin
        if (cmd.set)
        begin
            frame_reg[cmd.set_idx] <= key_frame;
            kind_reg[cmd.set_idx]  <= key_kind;
        end
    end

    // Lowest matching entry and lowest free entry.
    always_comb
    begin
        stat = '0;
        for (int i = frt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && frame_reg[i] == key_frame && kind_reg[i] == key_kind)
            begin
                stat.hit     = 1'b1;
                stat.hit_idx = frt_pkg::IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                stat.free_ok  = 1'b1;
                stat.free_idx = frt_pkg::IDX_W'(i);
            end
        end
    end

    assign sel_frame = frame_reg[sel_idx];
    assign valid     = valid_reg;

endmodule

/* rtl/fragment_reassembly_tracker.sv */
// Fragment reassembly tracker, top level: sequencer, configuration and output register.
// Depends on frt_pkg, frt_tag_match and frt_entry_ram.
// Steps: a fragment passes lookup, update and hand-over; a reject found in the lookup skips
// the update; a check reads each entry, then reads and hands over each report or one
// no-report result; a purge reads each entry and hands over one result. One transaction
// at a time: the next is taken once the result is in the output register. Reset clears valid bits.
module fragment_reassembly_tracker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // frame number, packet_type, frag_index, frag_count, flag_bits, time_stamp
    input  logic [111:0]  s_tdata,
    // req_type, header_valid
    input  logic [2:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // slot, done frame number, frame_class, total_frags, pts, missing_map, purged_count
    output logic [143:0]  m_tdata,
    // status
    output logic [3:0]    m_tuser,
    output logic          m_tlast,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata
);

    localparam int IW = frt_pkg::IDX_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOKUP = 4'd1;
    localparam logic [3:0] S_UPDATE = 4'd2;
    localparam logic [3:0] S_EMIT   = 4'd3;
    localparam logic [3:0] S_CHK_RD = 4'd4;
    localparam logic [3:0] S_CHK_EV = 4'd5;
    localparam logic [3:0] S_REP_RD = 4'd6;
    localparam logic [3:0] S_REP_EV = 4'd7;
    localparam logic [3:0] S_PRG_RD = 4'd8;
    localparam logic [3:0] S_PRG_EV = 4'd9;

    logic [3:0]   state_reg, state_next, ret_reg, ret_next;
    logic         hv_reg;
    logic [111:0] in_reg;
    logic [IW-1:0] slot_reg, slot_next, scan_reg, scan_next;
    logic          isnew_reg, isnew_next;
    logic [frt_pkg::ENTRIES-1:0] qual_reg, qual_next;
    logic [3:0]   pcnt_reg, pcnt_next;
    frt_pkg::result_t res_reg, res_next, out_reg;
    logic         out_valid_reg;
    logic [31:0]  now_reg, nack_age_reg, stale_reg;
    logic [7:0]   key_mask_reg, audio_reg;

    // Captured input fields.
    logic [31:0]  f_fid, f_ts;
    logic [7:0]   f_ptype, f_flags;
    logic [15:0]  f_idx, f_cnt;
    assign f_fid   = in_reg[31:0];
    assign f_ptype = in_reg[39:32];
    assign f_idx   = in_reg[55:40];
    assign f_cnt   = in_reg[71:56];
    assign f_flags = in_reg[79:72];
    assign f_ts    = in_reg[111:80];

    frt_pkg::tag_cmd_t   tcmd;
    frt_pkg::tag_stat_t  tstat;
    logic [31:0]         sel_frame;
    logic [frt_pkg::ENTRIES-1:0] tvalid;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr, mem_raddr;
    frt_pkg::entry_rec_t mem_wdata, mem_rdata;

    frt_tag_match u_tag (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_frame (f_fid),
        .key_kind  (f_ptype),
        .cmd       (tcmd),
        .sel_idx   (slot_reg),
        .stat      (tstat),
        .sel_frame (sel_frame),
        .valid     (tvalid)
    );

    frt_entry_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic s_fire, out_free;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer: lookup, read-modify-write of the entry memory and table walks.
    always_comb
    begin
        frt_pkg::entry_rec_t base, upd;
        logic [frt_pkg::MAP_W-1:0] miss;
        logic [frt_pkg::ENTRIES-1:0] qa, rest;
        logic q;
        logic [IW-1:0] low;
        logic [31:0] age;

        state_next = state_reg;
        ret_next   = ret_reg;
        slot_next  = slot_reg;
        scan_next  = scan_reg;
        isnew_next = isnew_reg;
        qual_next  = qual_reg;
        pcnt_next  = pcnt_reg;
        res_next   = res_reg;
        tcmd       = '0;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = scan_reg;
        base = '0;
        upd  = '0;
        miss = mem_rdata.rmap;
        qa   = '0;
        rest = '0;
        q    = 1'b0;
        low  = '0;
        age  = now_reg - mem_rdata.created;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    res_next  = '0;
                    scan_next = '0;
                    qual_next = '0;
                    pcnt_next = '0;
                    case (s_tuser[1:0])
                        frt_pkg::REQ_FRAG:  state_next = S_LOOKUP;
                        frt_pkg::REQ_CHECK: state_next = S_CHK_RD;
                        frt_pkg::REQ_PURGE: state_next = S_PRG_RD;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end

            // Early rejects, then the key match or a new entry.
            S_LOOKUP:
            begin
                res_next.last = 1'b1;
                ret_next      = S_IDLE;
                if (!hv_reg)
                begin
                    res_next.status = frt_pkg::ST_INVALID;
                    state_next      = S_EMIT;
                end
                else if (f_cnt == 16'd0)
                begin
                    res_next.status = frt_pkg::ST_ZERO;
                    state_next      = S_EMIT;
                end
                else if (f_cnt > 16'(frt_pkg::MAX_FRAGS))
                begin
                    res_next.status = frt_pkg::ST_TOO_MANY;
                    state_next      = S_EMIT;
                end
                else if (tstat.hit)
                begin
                    slot_next  = tstat.hit_idx;
                    mem_raddr  = tstat.hit_idx;
                    isnew_next = 1'b0;
                    state_next = S_UPDATE;
                end
                else if (tstat.free_ok)
                begin
                    slot_next    = tstat.free_idx;
                    isnew_next   = 1'b1;
                    tcmd.set     = 1'b1;
                    tcmd.set_idx = tstat.free_idx;
                    state_next   = S_UPDATE;
                end
                else
                begin
                    res_next.status = frt_pkg::ST_FULL;
                    state_next      = S_EMIT;
                end
            end

            // Mark the fragment and write the entry back.
            S_UPDATE:
            begin
                if (isnew_reg)
                begin
                    base.total   = f_cnt[frt_pkg::TOT_W-1:0];
                    base.count   = '0;
                    base.flags   = f_flags;
                    base.pts     = f_ts;
                    base.created = now_reg;
                    base.nacked  = 1'b0;
                    base.rmap    = '0;
                end
                else
                begin
                    base = mem_rdata;
                end
                upd       = base;
                mem_we    = 1'b1;
                mem_wdata = base;
                res_next.slot = slot_reg;
                state_next    = S_EMIT;
                if (f_idx >= 16'(base.total))
                begin
                    res_next.status = frt_pkg::ST_RANGE;
                end
                else if (base.rmap[f_idx[frt_pkg::BIT_W-1:0]])
                begin
                    res_next.status = frt_pkg::ST_DUP;
                end
                else
                begin
                    upd.rmap  = base.rmap | (frt_pkg::MAP_W'(1) << f_idx[frt_pkg::BIT_W-1:0]);
                    upd.count = base.count + frt_pkg::TOT_W'(1);
                    upd.flags = base.flags | f_flags;
                    mem_wdata = upd;
                    res_next.fid = f_fid;
                    if (upd.count < upd.total)
                    begin
                        res_next.status = frt_pkg::ST_STORED;
                    end
                    else
                    begin
                        res_next.status = frt_pkg::ST_COMPLETE;
                        res_next.total  = upd.total;
                        res_next.pts    = upd.pts;
                        if (f_ptype == audio_reg)
                            res_next.fclass = frt_pkg::CLS_AUDIO;
                        else if ((upd.flags & key_mask_reg) != 8'd0)
                            res_next.fclass = frt_pkg::CLS_KEY;
                        else
                            res_next.fclass = frt_pkg::CLS_PRED;
                        tcmd.clr     = 1'b1;
                        tcmd.clr_idx = slot_reg;
                    end
                end
            end

            // Hand the result to the output register.
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ret_reg;
                end
            end

            // Check, first pass: find the entries that need a report.
            S_CHK_RD:
            begin
                mem_raddr  = scan_reg;
                state_next = S_CHK_EV;
            end

            S_CHK_EV:
            begin
                miss = ~mem_rdata.rmap & frt_pkg::low_mask(mem_rdata.total);
                q = tvalid[scan_reg] && ((mem_rdata.flags & key_mask_reg) != 8'd0)
                    && !mem_rdata.nacked && (age >= nack_age_reg) && (miss != '0);
                qa = qual_reg;
                qa[scan_reg] = q;
                qual_next = qa;
                if (scan_reg == IW'(frt_pkg::ENTRIES - 1))
                begin
                    if (qa == '0)
                    begin
                        res_next.status = frt_pkg::ST_NACK_NONE;
                        res_next.last   = 1'b1;
                        ret_next        = S_IDLE;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_REP_RD;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + IW'(1);
                    state_next = S_CHK_RD;
                end
            end

            // Check, second pass: read the lowest flagged entry.
            S_REP_RD:
            begin
                for (int i = frt_pkg::ENTRIES - 1; i >= 0; i--)
                begin
                    if (qual_reg[i])
                    begin
                        low = IW'(i);
                    end
                end
                slot_next  = low;
                mem_raddr  = low;
                state_next = S_REP_EV;
            end

            S_REP_EV:
            begin
                miss = ~mem_rdata.rmap & frt_pkg::low_mask(mem_rdata.total);
                rest = qual_reg;
                rest[slot_reg] = 1'b0;
                qual_next = rest;
                upd = mem_rdata;
                upd.nacked = 1'b1;
                mem_we    = 1'b1;
                mem_wdata = upd;
                res_next.status = frt_pkg::ST_NACK;
                res_next.slot   = slot_reg;
                res_next.fid    = sel_frame;
                res_next.fclass = frt_pkg::CLS_KEY;
                res_next.total  = mem_rdata.total;
                res_next.pts    = mem_rdata.pts;
                res_next.miss   = miss;
                res_next.last   = (rest == '0);
                ret_next        = (rest == '0) ? S_IDLE : S_REP_RD;
                state_next      = S_EMIT;
            end

            // Purge: drop every entry older than the stale timeout.
            S_PRG_RD:
            begin
                mem_raddr  = scan_reg;
                state_next = S_PRG_EV;
            end

            S_PRG_EV:
            begin
                if (tvalid[scan_reg] && age > stale_reg)
                begin
                    tcmd.clr     = 1'b1;
                    tcmd.clr_idx = scan_reg;
                    pcnt_next    = (pcnt_reg == 4'd15) ? pcnt_reg : pcnt_reg + 4'd1;
                end
                if (scan_reg == IW'(frt_pkg::ENTRIES - 1))
                begin
                    res_next.status = frt_pkg::ST_PURGED;
                    res_next.purged = pcnt_next;
                    res_next.last   = 1'b1;
                    ret_next        = S_IDLE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    scan_next  = scan_reg + IW'(1);
                    state_next = S_PRG_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            slot_reg      <= '0;
            scan_reg      <= '0;
            isnew_reg     <= 1'b0;
            qual_reg      <= '0;
            pcnt_reg      <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            hv_reg        <= 1'b0;
            in_reg        <= '0;
            now_reg       <= '0;
            nack_age_reg  <= 32'd50;
            stale_reg     <= 32'd500;
            key_mask_reg  <= 8'd1;
            audio_reg     <= 8'd2;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            slot_reg  <= slot_next;
            scan_reg  <= scan_next;
            isnew_reg <= isnew_next;
            qual_reg  <= qual_next;
            pcnt_reg  <= pcnt_next;
            res_reg   <= res_next;

            // Input capture; a tick advances the millisecond counter at once.
            if (s_fire)
            begin
                hv_reg  <= s_tuser[2];
                in_reg  <= s_tdata;
                if (s_tuser[1:0] == frt_pkg::REQ_TICK)
                begin
                    now_reg <= now_reg + 32'd1;
                end
            end

            // Output register.
            if (state_reg == S_EMIT && out_free)
            begin
                out_reg       <= res_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration writes.
            if (cfg_we)
            begin
                case (cfg_addr)
                    frt_pkg::CFG_NACK_AGE: nack_age_reg <= cfg_wdata;
                    frt_pkg::CFG_STALE:    stale_reg    <= cfg_wdata;
                    frt_pkg::CFG_KEY_MASK: key_mask_reg <= cfg_wdata[7:0];
                    frt_pkg::CFG_AUDIO:    audio_reg    <= cfg_wdata[7:0];
                    default:               ;
                endcase
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.purged, out_reg.miss, out_reg.pts, out_reg.total,
                       out_reg.fclass, out_reg.fid, out_reg.slot};

endmodule
